/* sv/btrg_pkg.sv */
`default_nettype none

package btrg_pkg;

    // fixed field widths
    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned HOME_W   = 10;
    localparam int unsigned SURF_W   = 12;
    localparam int unsigned COLOR_W  = 16;
    localparam int unsigned X_W      = 12;
    localparam int unsigned Y_W      = 16;
    localparam int unsigned MASK_W   = 10;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // font
    localparam int unsigned GLYPH_COUNT = 96;
    localparam int unsigned GLYPH_ROWS  = 5;
    localparam int unsigned GLYPH_COLS  = 5;
    localparam int unsigned GLYPH_W     = GLYPH_ROWS * GLYPH_COLS;
    localparam int unsigned GLYPH_IDX_W = $clog2(GLYPH_COUNT);

    localparam int unsigned DEF_X_SCALE = 2;
    localparam int unsigned DEF_Y_SCALE = 3;

    // cursor movement
    localparam logic [3:0] CHAR_ADVANCE      = 4'd13;
    localparam logic [5:0] LINE_STEP         = 6'd32;
    localparam logic [6:0] TAB_STEP          = 7'd80;
    localparam logic [5:0] FIRST_LINE_OFFSET = 6'd42;
    localparam logic [1:0] SHADOW_SHIFT      = 2'd2;
    localparam logic [GLYPH_IDX_W-1:0] SOLID_GLYPH = GLYPH_IDX_W'(8'h5F);
    localparam logic [SURF_W-1:0] DEFAULT_WIDTH = 12'd640;

    // character codes
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CH_LC_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LC_Z  = 8'h7A;
    localparam logic [CHAR_W-1:0] CASE_GAP = 8'h20;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HOME_X       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOME_Y       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SURFACE_W    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_COLOR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SHADOW_COLOR = 3'd4;

    // register reset values
    localparam logic [HOME_W-1:0]  RST_HOME_X       = 10'd8;
    localparam logic [HOME_W-1:0]  RST_HOME_Y       = 10'd24;
    localparam logic [SURF_W-1:0]  RST_SURFACE_W    = 12'd640;
    localparam logic [COLOR_W-1:0] RST_TEXT_COLOR   = 16'h7BEF;
    localparam logic [COLOR_W-1:0] RST_SHADOW_COLOR = 16'h0000;

    typedef logic [GLYPH_W-1:0] t_glyph;

    function automatic logic [X_W-1:0] sat_x(input logic [X_W:0] v);
        sat_x = v[X_W] ? {X_W{1'b1}} : v[X_W-1:0];
    endfunction

    function automatic logic [Y_W-1:0] sat_y(input logic [Y_W:0] v);
        sat_y = v[Y_W] ? {Y_W{1'b1}} : v[Y_W-1:0];
    endfunction

    // row 0 in the top bits; bit 4 of a row is the leftmost column
    function automatic t_glyph font_glyph(input logic [GLYPH_IDX_W-1:0] idx);
        t_glyph g;
        case (idx)
            7'd0:  g = {5'h00,5'h00,5'h00,5'h00,5'h00};
            7'd1:  g = {5'h04,5'h04,5'h04,5'h00,5'h04};
            7'd2:  g = {5'h0A,5'h0A,5'h00,5'h00,5'h00};
            7'd3:  g = {5'h0A,5'h1F,5'h0A,5'h1F,5'h0A};
            7'd4:  g = {5'h0E,5'h14,5'h0E,5'h05,5'h0E};
            7'd5:  g = {5'h11,5'h04,5'h08,5'h11,5'h00};
            7'd6:  g = {5'h0C,5'h12,5'h0D,5'h12,5'h0E};
            7'd7:  g = {5'h04,5'h04,5'h00,5'h00,5'h00};
            7'd8:  g = {5'h04,5'h08,5'h08,5'h08,5'h04};
            7'd9:  g = {5'h08,5'h04,5'h04,5'h04,5'h08};
            7'd10: g = {5'h0A,5'h04,5'h1F,5'h04,5'h0A};
            7'd11: g = {5'h00,5'h04,5'h1F,5'h04,5'h00};
            7'd12: g = {5'h00,5'h00,5'h00,5'h04,5'h08};
            7'd13: g = {5'h00,5'h00,5'h1F,5'h00,5'h00};
            7'd14: g = {5'h00,5'h00,5'h00,5'h04,5'h00};
            7'd15: g = {5'h01,5'h02,5'h04,5'h08,5'h10};
            7'd16: g = {5'h0E,5'h11,5'h11,5'h11,5'h0E};
            7'd17: g = {5'h04,5'h0C,5'h04,5'h04,5'h1F};
            7'd18: g = {5'h0E,5'h01,5'h0E,5'h10,5'h1F};
            7'd19: g = {5'h0E,5'h01,5'h06,5'h01,5'h0E};
            7'd20: g = {5'h11,5'h11,5'h1F,5'h01,5'h01};
            7'd21: g = {5'h1F,5'h10,5'h1E,5'h01,5'h1E};
            7'd22: g = {5'h0E,5'h10,5'h1E,5'h11,5'h0E};
            7'd23: g = {5'h1F,5'h01,5'h02,5'h04,5'h08};
            7'd24: g = {5'h0E,5'h11,5'h0E,5'h11,5'h0E};
            7'd25: g = {5'h0E,5'h11,5'h0F,5'h01,5'h0E};
            7'd26: g = {5'h00,5'h04,5'h00,5'h04,5'h00};
            7'd27: g = {5'h00,5'h04,5'h00,5'h04,5'h08};
            7'd28: g = {5'h02,5'h04,5'h08,5'h04,5'h02};
            7'd29: g = {5'h00,5'h1F,5'h00,5'h1F,5'h00};
            7'd30: g = {5'h08,5'h04,5'h02,5'h04,5'h08};
            7'd31: g = {5'h0E,5'h01,5'h06,5'h00,5'h04};
            7'd32: g = {5'h0E,5'h17,5'h15,5'h10,5'h0E};
            7'd33: g = {5'h04,5'h0A,5'h11,5'h1F,5'h11};
            7'd34: g = {5'h1E,5'h11,5'h1E,5'h11,5'h1E};
            7'd35: g = {5'h0E,5'h10,5'h10,5'h10,5'h0E};
            7'd36: g = {5'h1E,5'h11,5'h11,5'h11,5'h1E};
            7'd37: g = {5'h1F,5'h10,5'h1E,5'h10,5'h1F};
            7'd38: g = {5'h1F,5'h10,5'h1E,5'h10,5'h10};
            7'd39: g = {5'h0E,5'h10,5'h16,5'h11,5'h0E};
            7'd40: g = {5'h11,5'h11,5'h1F,5'h11,5'h11};
            7'd41: g = {5'h1F,5'h04,5'h04,5'h04,5'h1F};
            7'd42: g = {5'h01,5'h01,5'h01,5'h11,5'h0E};
            7'd43: g = {5'h11,5'h12,5'h1C,5'h12,5'h11};
            7'd44: g = {5'h10,5'h10,5'h10,5'h10,5'h1F};
            7'd45: g = {5'h11,5'h1B,5'h15,5'h11,5'h11};
            7'd46: g = {5'h11,5'h19,5'h15,5'h13,5'h11};
            7'd47: g = {5'h0E,5'h11,5'h11,5'h11,5'h0E};
            7'd48: g = {5'h1E,5'h11,5'h1E,5'h10,5'h10};
            7'd49: g = {5'h0E,5'h11,5'h11,5'h15,5'h0D};
            7'd50: g = {5'h1E,5'h11,5'h1E,5'h12,5'h11};
            7'd51: g = {5'h0E,5'h10,5'h0E,5'h01,5'h1E};
            7'd52: g = {5'h1F,5'h04,5'h04,5'h04,5'h04};
            7'd53: g = {5'h11,5'h11,5'h11,5'h11,5'h0E};
            7'd54: g = {5'h11,5'h11,5'h11,5'h0A,5'h04};
            7'd55: g = {5'h11,5'h11,5'h15,5'h1B,5'h11};
            7'd56: g = {5'h11,5'h0A,5'h04,5'h0A,5'h11};
            7'd57: g = {5'h11,5'h0A,5'h04,5'h04,5'h04};
            7'd58: g = {5'h1F,5'h02,5'h04,5'h08,5'h1F};
            7'd59: g = {5'h1E,5'h10,5'h10,5'h10,5'h1E};
            7'd60: g = {5'h10,5'h08,5'h04,5'h02,5'h01};
            7'd61: g = {5'h0F,5'h01,5'h01,5'h01,5'h0F};
            7'd62: g = {5'h04,5'h0A,5'h11,5'h00,5'h00};
            7'd63: g = {5'h00,5'h00,5'h00,5'h00,5'h1F};
            7'd64: g = {5'h08,5'h04,5'h00,5'h00,5'h00};
            7'd65: g = {5'h00,5'h0E,5'h01,5'h0F,5'h11};
            7'd66: g = {5'h10,5'h1E,5'h11,5'h11,5'h1E};
            7'd67: g = {5'h00,5'h0E,5'h10,5'h10,5'h0E};
            7'd68: g = {5'h01,5'h0F,5'h11,5'h11,5'h0F};
            7'd69: g = {5'h00,5'h0E,5'h1F,5'h10,5'h0E};
            7'd70: g = {5'h06,5'h08,5'h1E,5'h08,5'h08};
            7'd71: g = {5'h00,5'h0E,5'h11,5'h0F,5'h06};
            7'd72: g = {5'h10,5'h1E,5'h11,5'h11,5'h11};
            7'd73: g = {5'h04,5'h00,5'h0C,5'h04,5'h1F};
            7'd74: g = {5'h01,5'h00,5'h02,5'h12,5'h0C};
            7'd75: g = {5'h10,5'h12,5'h18,5'h12,5'h11};
            7'd76: g = {5'h0C,5'h04,5'h04,5'h04,5'h1F};
            7'd77: g = {5'h00,5'h1B,5'h15,5'h11,5'h11};
            7'd78: g = {5'h00,5'h1E,5'h11,5'h11,5'h11};
            7'd79: g = {5'h00,5'h0E,5'h11,5'h11,5'h0E};
            7'd80: g = {5'h00,5'h1E,5'h11,5'h1E,5'h10};
            7'd81: g = {5'h00,5'h0F,5'h11,5'h0F,5'h01};
            7'd82: g = {5'h00,5'h16,5'h18,5'h10,5'h10};
            7'd83: g = {5'h00,5'h0E,5'h18,5'h03,5'h1E};
            7'd84: g = {5'h08,5'h1E,5'h08,5'h08,5'h06};
            7'd85: g = {5'h00,5'h11,5'h11,5'h11,5'h0E};
            7'd86: g = {5'h00,5'h11,5'h11,5'h0A,5'h04};
            7'd87: g = {5'h00,5'h11,5'h15,5'h1B,5'h0A};
            7'd88: g = {5'h00,5'h11,5'h0A,5'h0A,5'h11};
            7'd89: g = {5'h00,5'h11,5'h0A,5'h04,5'h08};
            7'd90: g = {5'h00,5'h1F,5'h04,5'h08,5'h1F};
            7'd91: g = {5'h06,5'h08,5'h10,5'h08,5'h06};
            7'd92: g = {5'h04,5'h04,5'h04,5'h04,5'h04};
            7'd93: g = {5'h0C,5'h02,5'h01,5'h02,5'h0C};
            7'd94: g = {5'h08,5'h14,5'h00,5'h00,5'h00};
            7'd95: g = {5'h1F,5'h1F,5'h1F,5'h1F,5'h1F};
            default: g = '0;
        endcase
        font_glyph = g;
    endfunction

endpackage

`default_nettype wire

/* sv/btrg_ram.sv */
`default_nettype none

module btrg_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* sv/bitmap_text_row_generator.sv */
`default_nettype none

// channel     dir  handshake                     payload
// s_axis      in   s_axis_tvalid/s_axis_tready   tdata char_code, tuser new_text
// m_axis      out  m_axis_tvalid/m_axis_tready   tdata row fields, tlast last_row
// cfg         in   i_cfg_we                      i_cfg_idx, i_cfg_data
//
// a printable character gives 10*Y_SCALE rows, one per cycle unless m_axis
// stalls, from the row sequencer through the font ram read and the output
// register. the next character is taken in the cycle of the last row, so
// a character waits for the last row of the one before; control codes give no rows.
// after reset the font ram is loaded from the glyph table, during which
// s_axis_tready stays low; config writes are taken.
// a stall on m_axis holds the whole row pipe; the cursor moves at transfer.

module bitmap_text_row_generator #(
    parameter int unsigned X_SCALE = btrg_pkg::DEF_X_SCALE,
    parameter int unsigned Y_SCALE = btrg_pkg::DEF_Y_SCALE
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  wire logic        s_axis_tuser,   // [0] new_text
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [11:0] pixel_x, [27:12] pixel_y, [37:28] row_mask, [53:38] pixel_color,
    // [55:54] zero
    output logic      [55:0] m_axis_tdata,
    output logic             m_axis_tlast,   // last_row
    input  wire logic        i_cfg_we,
    input  wire logic [btrg_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [btrg_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int unsigned X_W      = btrg_pkg::X_W;
    localparam int unsigned Y_W      = btrg_pkg::Y_W;
    localparam int unsigned MASK_W   = btrg_pkg::MASK_W;
    localparam int unsigned COLOR_W  = btrg_pkg::COLOR_W;
    localparam int unsigned HOME_W   = btrg_pkg::HOME_W;
    localparam int unsigned SURF_W   = btrg_pkg::SURF_W;
    localparam int unsigned GI_W     = btrg_pkg::GLYPH_IDX_W;
    localparam int unsigned NGLYPH   = btrg_pkg::GLYPH_COUNT;
    localparam int unsigned FILL_W   = $clog2(NGLYPH + 1);
    localparam int unsigned G_ROWS   = btrg_pkg::GLYPH_ROWS;
    localparam int unsigned G_COLS   = btrg_pkg::GLYPH_COLS;
    localparam int unsigned ROW_W    = $clog2(G_ROWS);
    localparam int unsigned PASS_ROWS = G_ROWS * Y_SCALE;
    localparam int unsigned OFF_W    = $clog2(PASS_ROWS);
    localparam int unsigned SUB_W    = (Y_SCALE > 1) ? $clog2(Y_SCALE) : 1;

    // configuration registers
    logic [HOME_W-1:0]  r_home_x, r_home_y;
    logic [SURF_W-1:0]  r_surf_w;
    logic [COLOR_W-1:0] r_text_color, r_shadow_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_home_x       <= btrg_pkg::RST_HOME_X;
            r_home_y       <= btrg_pkg::RST_HOME_Y;
            r_surf_w       <= btrg_pkg::RST_SURFACE_W;
            r_text_color   <= btrg_pkg::RST_TEXT_COLOR;
            r_shadow_color <= btrg_pkg::RST_SHADOW_COLOR;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                btrg_pkg::CFG_HOME_X:       r_home_x       <= i_cfg_data[HOME_W-1:0];
                btrg_pkg::CFG_HOME_Y:       r_home_y       <= i_cfg_data[HOME_W-1:0];
                btrg_pkg::CFG_SURFACE_W:    r_surf_w       <= i_cfg_data[SURF_W-1:0];
                btrg_pkg::CFG_TEXT_COLOR:   r_text_color   <= i_cfg_data[COLOR_W-1:0];
                btrg_pkg::CFG_SHADOW_COLOR: r_shadow_color <= i_cfg_data[COLOR_W-1:0];
                default: ;
            endcase
        end
    end

    // font ram load after reset
    logic [FILL_W-1:0] r_fill_cnt;
    logic              r_fill_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_cnt  <= '0;
            r_fill_done <= 1'b0;
        end else if (!r_fill_done) begin
            r_fill_cnt <= r_fill_cnt + 1'b1;
            if (r_fill_cnt == FILL_W'(NGLYPH - 1)) begin
                r_fill_done <= 1'b1;
            end
        end
    end

    // row pipe control
    logic r_job_active, r_s1_valid, r_out_valid;
    logic adv, job_at_last, in_xfer, is_print;

    assign adv = !r_out_valid || m_axis_tready;

    // job registers
    logic [GI_W-1:0]  r_glyph;
    logic [X_W-1:0]   r_tx, r_sx;
    logic [Y_W-1:0]   r_ty, r_sy;
    logic             r_pass;
    logic [OFF_W-1:0] r_off;
    logic [ROW_W-1:0] r_row;
    logic [SUB_W-1:0] r_sub;

    assign job_at_last = r_pass && (r_off == OFF_W'(PASS_ROWS - 1));
    assign s_axis_tready = r_fill_done && (!r_job_active || (adv && job_at_last));
    assign in_xfer = s_axis_tvalid && s_axis_tready;

    // cursor
    logic [X_W-1:0] r_cx, n_cx;
    logic [Y_W-1:0] r_cy, n_cy;
    logic [X_W-1:0] cx0, x_adv, x_home;
    logic [Y_W-1:0] cy0, y_down;
    logic [7:0]     ch;
    logic [GI_W-1:0] glyph;
    logic [SURF_W-1:0] width;
    logic [7:0]  tab_q;
    logic [15:0] tab_prod;
    logic [12:0] tab_next;

    assign x_home = X_W'(r_home_x);

    always_comb begin
        cx0 = s_axis_tuser ? x_home : r_cx;
        cy0 = s_axis_tuser ? (Y_W'(r_home_y) + Y_W'(btrg_pkg::FIRST_LINE_OFFSET)) : r_cy;
        ch = s_axis_tdata;
        if (ch inside {[btrg_pkg::CH_LC_A:btrg_pkg::CH_LC_Z]}) begin
            ch = ch - btrg_pkg::CASE_GAP;
        end
        is_print = (ch >= btrg_pkg::CH_SPACE);
        glyph = ch[7] ? btrg_pkg::SOLID_GLYPH : GI_W'(ch - btrg_pkg::CH_SPACE);
        width = (r_surf_w == '0) ? btrg_pkg::DEFAULT_WIDTH : r_surf_w;
        y_down = btrg_pkg::sat_y({1'b0, cy0} + (Y_W + 1)'(btrg_pkg::LINE_STEP));
        x_adv = btrg_pkg::sat_x({1'b0, cx0} + (X_W + 1)'(btrg_pkg::CHAR_ADVANCE));
        // x/80 as (x/16)/5, with n/5 = (n*205)>>10 exact for these n
        tab_prod = 16'(cx0[X_W-1:4]) * 16'd205;
        tab_q = 8'(tab_prod[15:10]) + 8'd1;
        tab_next = 13'(tab_q * 8'(btrg_pkg::TAB_STEP));
        n_cx = cx0;
        n_cy = cy0;
        if (is_print) begin
            // wrap when x >= width - home_x, rewritten without a signed result
            if (({2'b0, x_adv} + 14'(r_home_x)) >= 14'(width)) begin
                n_cx = x_home;
                n_cy = y_down;
            end else begin
                n_cx = x_adv;
            end
        end else begin
            case (ch)
                btrg_pkg::CH_BS: begin
                    if ({1'b0, cx0} < ((X_W + 1)'(r_home_x) + (X_W + 1)'(btrg_pkg::CHAR_ADVANCE)))
                    begin
                        n_cx = x_home;
                    end else begin
                        n_cx = cx0 - X_W'(btrg_pkg::CHAR_ADVANCE);
                    end
                end
                btrg_pkg::CH_TAB: n_cx = btrg_pkg::sat_x(tab_next);
                btrg_pkg::CH_LF: begin
                    n_cx = x_home;
                    n_cy = y_down;
                end
                btrg_pkg::CH_CR: n_cx = x_home;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx <= X_W'(btrg_pkg::RST_HOME_X);
            r_cy <= Y_W'(btrg_pkg::RST_HOME_Y) + Y_W'(btrg_pkg::FIRST_LINE_OFFSET);
        end else if (in_xfer) begin
            r_cx <= n_cx;
            r_cy <= n_cy;
        end
    end

    // row sequencer
    logic start_job;
    assign start_job = in_xfer && is_print;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_active <= 1'b0;
            r_pass       <= 1'b0;
            r_off        <= '0;
            r_row        <= '0;
            r_sub        <= '0;
        end else if (start_job) begin
            r_job_active <= 1'b1;
            r_pass       <= 1'b0;
            r_off        <= '0;
            r_row        <= '0;
            r_sub        <= '0;
        end else if (r_job_active && adv) begin
            if (job_at_last) begin
                r_job_active <= 1'b0;
            end else if (r_off == OFF_W'(PASS_ROWS - 1)) begin
                r_pass <= 1'b1;
                r_off  <= '0;
                r_row  <= '0;
                r_sub  <= '0;
            end else begin
                r_off <= r_off + 1'b1;
                if (r_sub == SUB_W'(Y_SCALE - 1)) begin
                    r_sub <= '0;
                    r_row <= r_row + 1'b1;
                end else begin
                    r_sub <= r_sub + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start_job) begin
            r_glyph <= glyph;
            r_tx    <= cx0;
            r_ty    <= cy0;
            r_sx    <= btrg_pkg::sat_x({1'b0, cx0} + (X_W + 1)'(btrg_pkg::SHADOW_SHIFT));
            r_sy    <= btrg_pkg::sat_y({1'b0, cy0} + (Y_W + 1)'(btrg_pkg::SHADOW_SHIFT));
        end
    end

    // font ram: loaded once, then read at the job's glyph every issued row
    logic                    ram_re;
    btrg_pkg::t_glyph        ram_rdata;

    assign ram_re = r_job_active && adv;

    btrg_ram #(
        .WIDTH (btrg_pkg::GLYPH_W),
        .DEPTH (NGLYPH)
    ) u_font_ram (
        .i_clk   (i_clk),
        .i_we    (!r_fill_done),
        .i_waddr (r_fill_cnt[GI_W-1:0]),
        .i_wdata (btrg_pkg::font_glyph(r_fill_cnt[GI_W-1:0])),
        .i_re    (ram_re),
        .i_raddr (r_glyph),
        .o_rdata (ram_rdata)
    );

    // stage 1: alongside the ram read data
    logic [X_W-1:0]     r_s1_x;
    logic [Y_W-1:0]     r_s1_y;
    logic [ROW_W-1:0]   r_s1_row;
    logic [COLOR_W-1:0] r_s1_color;
    logic               r_s1_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (adv) begin
            r_s1_valid <= r_job_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ram_re) begin
            r_s1_x     <= r_pass ? r_tx : r_sx;
            r_s1_y     <= btrg_pkg::sat_y({1'b0, (r_pass ? r_ty : r_sy)} + (Y_W + 1)'(r_off));
            r_s1_row   <= r_row;
            r_s1_color <= r_pass ? r_text_color : r_shadow_color;
            r_s1_last  <= job_at_last;
        end
    end

    // scaled row mask
    logic [G_COLS-1:0] font_row;
    logic [MASK_W-1:0] row_mask;

    always_comb begin
        font_row = ram_rdata[(G_ROWS - 1) * G_COLS +: G_COLS];
        for (int r = 0; r < G_ROWS; r++) begin
            if (r_s1_row == ROW_W'(r)) begin
                font_row = ram_rdata[(G_ROWS - 1 - r) * G_COLS +: G_COLS];
            end
        end
        row_mask = '0;
        for (int c = 0; c < G_COLS; c++) begin
            for (int k = 0; k < X_SCALE; k++) begin
                if (c * X_SCALE + k < MASK_W) begin
                    row_mask[c * X_SCALE + k] = font_row[G_COLS - 1 - c];
                end
            end
        end
    end

    // output register
    logic [X_W-1:0]     r_out_x;
    logic [Y_W-1:0]     r_out_y;
    logic [MASK_W-1:0]  r_out_mask;
    logic [COLOR_W-1:0] r_out_color;
    logic               r_out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_s1_valid) begin
            r_out_x     <= r_s1_x;
            r_out_y     <= r_s1_y;
            r_out_mask  <= row_mask;
            r_out_color <= r_s1_color;
            r_out_last  <= r_s1_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_color, r_out_mask, r_out_y, r_out_x};
    assign m_axis_tlast  = r_out_last;

    // a new character only enters on the last row of the one in progress
    a_accept_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && r_job_active) |-> (adv && job_at_last))
        else $error("character taken while rows remain");

    // no character before the font is loaded
    a_fill_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> r_fill_done)
        else $error("input ready during font load");

    // a stalled output holds the pipe behind it
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready && r_s1_valid) |=> (r_s1_valid && $stable(r_s1_y)))
        else $error("stage 1 moved under stall");

    // row counter stays within one pass
    a_off_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_job_active |-> (r_off <= OFF_W'(PASS_ROWS - 1)))
        else $error("row offset out of range");

endmodule

`default_nettype wire
